// ===== sv/rmth_pkg.sv =====
// rmth_pkg: shared constants and types of the running median block
// used by the controller, datapath, top level and checker

package rmth_pkg;

  localparam int unsigned HEAP_DEPTH_DEF = 512;
  localparam int unsigned SAMPLE_W       = 32;
  localparam int unsigned MED_W          = 33;
  localparam int unsigned CNT_W          = 11;

  // datapath micro operations
  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_REPL_LOW,
    CMD_PUSH_UP_S,
    CMD_PUSH_UP_M,
    CMD_POP_UP,
    CMD_POP_LD,
    CMD_PUSH_LOW,
    CMD_DN_L,
    CMD_DN_R,
    CMD_DN_C,
    CMD_UP,
    CMD_UP_C,
    CMD_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic full;       // upper heap or whole store full, sample is dropped
    logic less;       // sample below lower top
    logic dn_leaf;    // sift down reached a leaf
    logic dn_go;      // sift down moves one level
    logic up_root;    // sift up reached the root
    logic up_go;      // sift up moves one level
    logic rebal;      // upper heap larger than lower heap
    logic pop_empty;  // upper heap holds a single element
  } dp_stat_t;

endpackage

// ===== sv/rmth_ram.sv =====
// rmth_ram: generic single write, single read ram with registered read
// no dependencies

module rmth_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rmth_ctrl.sv =====
// rmth_ctrl: sequencer of heap operations for one sample
// depends on rmth_pkg for command and status types

module rmth_ctrl import rmth_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_DN_L   = 4'd2;
  localparam logic [3:0] S_DN_R   = 4'd3;
  localparam logic [3:0] S_DN_C   = 4'd4;
  localparam logic [3:0] S_UP     = 4'd5;
  localparam logic [3:0] S_UP_C   = 4'd6;
  localparam logic [3:0] S_NEXT   = 4'd7;
  localparam logic [3:0] S_POP_LD = 4'd8;
  localparam logic [3:0] S_RESULT = 4'd9;

  localparam logic [1:0] PH_REPL_LOW = 2'd0;
  localparam logic [1:0] PH_PUSH_UP  = 2'd1;
  localparam logic [1:0] PH_REPL_UP  = 2'd2;
  localparam logic [1:0] PH_PUSH_LOW = 2'd3;

  logic [3:0] state_q, state_d;
  logic [1:0] ph_q, ph_d;
  logic       out_valid_q, out_valid_d;

  // next state and command
  always_comb begin
    state_d     = state_q;
    ph_d        = ph_q;
    cmd_o.op    = CMD_IDLE;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = CMD_LOAD;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (stat_i.full) begin
          state_d = S_RESULT;
        end else if (stat_i.less) begin
          cmd_o.op = CMD_REPL_LOW;
          ph_d     = PH_REPL_LOW;
          state_d  = S_DN_L;
        end else begin
          cmd_o.op = CMD_PUSH_UP_S;
          ph_d     = PH_PUSH_UP;
          state_d  = S_UP;
        end
      end
      S_DN_L: begin
        cmd_o.op = CMD_DN_L;
        state_d  = stat_i.dn_leaf ? S_NEXT : S_DN_R;
      end
      S_DN_R: begin
        cmd_o.op = CMD_DN_R;
        state_d  = S_DN_C;
      end
      S_DN_C: begin
        cmd_o.op = CMD_DN_C;
        state_d  = stat_i.dn_go ? S_DN_L : S_NEXT;
      end
      S_UP: begin
        cmd_o.op = CMD_UP;
        state_d  = stat_i.up_root ? S_NEXT : S_UP_C;
      end
      S_UP_C: begin
        cmd_o.op = CMD_UP_C;
        state_d  = stat_i.up_go ? S_UP : S_NEXT;
      end
      S_NEXT: begin
        unique case (ph_q)
          PH_REPL_LOW: begin
            cmd_o.op = CMD_PUSH_UP_M;
            ph_d     = PH_PUSH_UP;
            state_d  = S_UP;
          end
          PH_PUSH_UP: begin
            if (stat_i.rebal) begin
              cmd_o.op = CMD_POP_UP;
              ph_d     = PH_REPL_UP;
              state_d  = stat_i.pop_empty ? S_NEXT : S_POP_LD;
            end else begin
              state_d = S_RESULT;
            end
          end
          PH_REPL_UP: begin
            cmd_o.op = CMD_PUSH_LOW;
            ph_d     = PH_PUSH_LOW;
            state_d  = S_UP;
          end
          default: begin
            state_d = S_RESULT;
          end
        endcase
      end
      S_POP_LD: begin
        cmd_o.op = CMD_POP_LD;
        state_d  = S_DN_L;
      end
      S_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op    = CMD_RESULT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ph_q        <= PH_REPL_LOW;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/rmth_dp.sv =====
// rmth_dp: heap storage, sift registers, sizes and result registers
// depends on rmth_pkg and rmth_ram

module rmth_dp import rmth_pkg::*; #(
  parameter int unsigned HEAP_DEPTH = HEAP_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dp_cmd_t                    cmd_i,
  output dp_stat_t                   stat_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic signed [MED_W-1:0]    median_doubled_o,
  output logic [CNT_W-1:0]           element_count_o,
  output logic                       rejected_o
);

  localparam int unsigned AW = $clog2(HEAP_DEPTH);
  localparam int unsigned SW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned TW = SW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(HEAP_DEPTH);
  localparam logic [TW-1:0] FULL_T  = TW'(2 * HEAP_DEPTH);

  logic [SW-1:0]              low_size_q, up_size_q;
  logic signed [SAMPLE_W-1:0] low_top_q, up_top_q, val_q, moved_q, sample_q, bv_q;
  logic [AW-1:0]              idx_q;
  logic [SW-1:0]              lim_q;
  logic                       sel_q;  // 1: lower max-heap, 0: upper min-heap
  logic                       rej_q;
  logic signed [MED_W-1:0]    med_q;
  logic [CNT_W-1:0]           cnt_q;
  logic                       res_rej_q;

  logic                       we;
  logic [AW-1:0]              waddr, raddr;
  logic signed [SAMPLE_W-1:0] wdata, rdata, rd_lo, rd_up;

  function automatic logic ranks(input logic is_max, input logic signed [SAMPLE_W-1:0] a,
                                 input logic signed [SAMPLE_W-1:0] b);
    return is_max ? (a > b) : (a < b);
  endfunction

  // heap memories
  rmth_ram #(.WIDTH(SAMPLE_W), .DEPTH(HEAP_DEPTH)) u_low_ram (
    .clk_i   (clk_i),
    .we_i    (we && sel_q),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd_lo)
  );

  rmth_ram #(.WIDTH(SAMPLE_W), .DEPTH(HEAP_DEPTH)) u_up_ram (
    .clk_i   (clk_i),
    .we_i    (we && !sel_q),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd_up)
  );

  assign rdata = sel_q ? rd_lo : rd_up;

  // child and parent indexes
  logic [AW:0]                child_l, child_r;
  logic [TW-1:0]              l_t, r_t, lim_t, tot;
  logic [AW-1:0]              parent, cand_idx;
  logic                       leaf, r_in, use_r, dn_go, up_go;
  logic signed [SAMPLE_W-1:0] cand;

  always_comb begin
    child_l  = {idx_q, 1'b1};
    child_r  = child_l + 1'b1;
    l_t      = TW'(child_l);
    r_t      = TW'(child_r);
    lim_t    = TW'(lim_q);
    leaf     = (l_t >= lim_t);
    r_in     = (r_t < lim_t);
    parent   = (idx_q - 1'b1) >> 1;
    use_r    = r_in && ranks(sel_q, rdata, bv_q);
    cand     = use_r ? rdata : bv_q;
    cand_idx = use_r ? child_r[AW-1:0] : child_l[AW-1:0];
    dn_go    = ranks(sel_q, cand, val_q);
    up_go    = ranks(sel_q, val_q, rdata);
    tot      = TW'(low_size_q) + TW'(up_size_q);
  end

  // status to the controller
  always_comb begin
    stat_o.full      = (up_size_q >= DEPTH_S) || (tot >= FULL_T);
    stat_o.less      = (low_size_q != '0) && (sample_q < low_top_q);
    stat_o.dn_leaf   = leaf;
    stat_o.dn_go     = dn_go;
    stat_o.up_root   = (idx_q == '0);
    stat_o.up_go     = up_go;
    stat_o.rebal     = (up_size_q > low_size_q);
    stat_o.pop_empty = (up_size_q == SW'(1));
  end

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = val_q;
    raddr = '0;
    unique case (cmd_i.op)
      CMD_POP_UP: raddr = AW'(up_size_q - 1'b1);
      CMD_DN_L: begin
        raddr = child_l[AW-1:0];
        we    = leaf;
      end
      CMD_DN_R: raddr = child_r[AW-1:0];
      CMD_DN_C: begin
        we = 1'b1;
        if (dn_go) begin
          wdata = cand;
        end
      end
      CMD_UP: begin
        if (idx_q == '0) begin
          we = 1'b1;
        end else begin
          raddr = parent;
        end
      end
      CMD_UP_C: begin
        we = 1'b1;
        if (up_go) begin
          wdata = rdata;
        end
      end
      default: begin
      end
    endcase
  end

  // result values
  logic signed [MED_W-1:0]    med_d;
  logic [TW+CNT_W-1:0]        cnt_ext;

  always_comb begin
    priority if (low_size_q == '0) begin
      med_d = '0;
    end else if ((low_size_q > up_size_q) || (up_size_q == '0)) begin
      med_d = {low_top_q, 1'b0};
    end else begin
      med_d = {low_top_q[SAMPLE_W-1], low_top_q} + {up_top_q[SAMPLE_W-1], up_top_q};
    end
    cnt_ext = {{CNT_W{1'b0}}, tot};
  end

  // heap sizes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_size_q <= '0;
      up_size_q  <= '0;
    end else begin
      unique case (cmd_i.op)
        CMD_PUSH_UP_S, CMD_PUSH_UP_M: up_size_q <= up_size_q + 1'b1;
        CMD_POP_UP:                   up_size_q <= up_size_q - 1'b1;
        CMD_PUSH_LOW:                 low_size_q <= low_size_q + 1'b1;
        default: begin
        end
      endcase
    end
  end

  // sift and result registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      CMD_LOAD: begin
        sample_q <= sample_i;
        rej_q    <= stat_o.full;
      end
      CMD_REPL_LOW: begin
        sel_q   <= 1'b1;
        val_q   <= sample_q;
        moved_q <= low_top_q;
        lim_q   <= low_size_q;
        idx_q   <= '0;
      end
      CMD_PUSH_UP_S: begin
        sel_q <= 1'b0;
        idx_q <= AW'(up_size_q);
        val_q <= sample_q;
      end
      CMD_PUSH_UP_M: begin
        sel_q <= 1'b0;
        idx_q <= AW'(up_size_q);
        val_q <= moved_q;
      end
      CMD_POP_UP: begin
        sel_q   <= 1'b0;
        moved_q <= up_top_q;
        lim_q   <= up_size_q - 1'b1;
        idx_q   <= '0;
      end
      CMD_POP_LD: begin
        val_q <= rdata;
        idx_q <= '0;
      end
      CMD_PUSH_LOW: begin
        sel_q <= 1'b1;
        idx_q <= AW'(low_size_q);
        val_q <= moved_q;
      end
      CMD_DN_R: bv_q <= rdata;
      CMD_DN_C: begin
        if (dn_go) begin
          idx_q <= cand_idx;
        end
      end
      CMD_UP_C: begin
        if (up_go) begin
          idx_q <= parent;
        end
      end
      CMD_RESULT: begin
        med_q     <= med_d;
        cnt_q     <= cnt_ext[CNT_W-1:0];
        res_rej_q <= rej_q;
      end
      default: begin
      end
    endcase
    // mirror of each heap root
    if (we && (waddr == '0)) begin
      if (sel_q) begin
        low_top_q <= wdata;
      end else begin
        up_top_q <= wdata;
      end
    end
  end

  assign median_doubled_o = med_q;
  assign element_count_o  = cnt_q;
  assign rejected_o       = res_rej_q;

endmodule

// ===== sv/running_median_two_heaps_unit.sv =====
// running_median_two_heaps_unit: top level of the running median block
// depends on rmth_pkg, rmth_ctrl, rmth_dp and rmth_ram
//
// Usage:
//   input channel: in_valid_i / in_stall_o carry one signed 32-bit sample per beat
//   output channel: out_valid_o / out_stall_i carry one result beat per sample:
//   twice the median, the element count and a rejected flag
//   a lower max-heap and an upper min-heap live in two single-port-read rams;
//   the roots are mirrored in registers
//   one sample at a time: an insert runs a lower sift down, an upper sift up,
//   an upper pop with its sift down and a lower sift up as needed; each level
//   of a sift down walks S_DN_L, S_DN_R and S_DN_C and each level of a sift
//   up walks S_UP and S_UP_C, paced by the one registered read port of each
//   heap ram; a rejected sample (upper heap or whole store full) skips the
//   heaps; the result registers load in S_RESULT, reached through S_NEXT
//   after the last heap write; the result register
//   frees the input side, so a new sample is taken while a result waits
//   a stalled result holds; the next item finishes only once it is taken
//   reset clears the heap sizes and the valid flags; heap contents are not
//   cleared, no clearing pass is needed

module running_median_two_heaps_unit import rmth_pkg::*; #(
  parameter int unsigned HEAP_DEPTH = HEAP_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [MED_W-1:0]    median_doubled_o,
  output logic [CNT_W-1:0]           element_count_o,
  output logic                       rejected_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rmth_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  rmth_dp #(.HEAP_DEPTH(HEAP_DEPTH)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .sample_i         (sample_i),
    .median_doubled_o (median_doubled_o),
    .element_count_o  (element_count_o),
    .rejected_o       (rejected_o)
  );

endmodule

// ===== sv/rmth_checker.sv =====
// rmth_checker: port level assertions for the running median block
// depends on rmth_pkg; bound to running_median_two_heaps_unit

module rmth_checker import rmth_pkg::*; #(
  parameter int unsigned HEAP_DEPTH = HEAP_DEPTH_DEF
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [CNT_W-1:0]           element_count_o,
  input logic                       rejected_o
);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(2 * HEAP_DEPTH);

  // a stalled result beat stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // an accepted sample makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after a beat");

  // a result only rises after the block was working on an item
  a_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without work");

  // a rejected sample reports a full store
  a_rej_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> element_count_o == CNT_FULL)
    else $error("rejected while not full");

endmodule

bind running_median_two_heaps_unit rmth_checker #(.HEAP_DEPTH(HEAP_DEPTH)) u_rmth_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .element_count_o (element_count_o),
  .rejected_o      (rejected_o)
);
